// ----- rtl/core/rc5_block_encrypt_assert.svh -----
// Assertion macros for the RC5 block.
`ifndef RC5_BLOCK_ENCRYPT_ASSERT_SVH
`define RC5_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication.
`define RC5_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc5 assertion failed");

// Next-cycle implication.
`define RC5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc5 assertion failed");

`endif

// ----- rtl/core/rc5_pkg.sv -----
package rc5_pkg;

  localparam int WORD_W     = 32;
  localparam int ROUNDS_DEF = 12;
  localparam int KEY_WORDS  = 26;
  localparam int KEY_IDX_W  = 7;
  localparam int ROT_W      = 5;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic step;
    logic push;
  } seq_ctl_t;

  // Expanded key schedule; indexes past the table read as zero.
  function automatic word_t key_at(key_idx_t idx);
    word_t k;
    unique case (idx)
      7'd0:    k = 32'hA9915556;
      7'd1:    k = 32'h48E44110;
      7'd2:    k = 32'h9F32308F;
      7'd3:    k = 32'h27F41D3E;
      7'd4:    k = 32'hCF4F3523;
      7'd5:    k = 32'hEAC3C6B4;
      7'd6:    k = 32'hE9EA5E03;
      7'd7:    k = 32'hE5974BBA;
      7'd8:    k = 32'h334D7692;
      7'd9:    k = 32'h2C6BCF2E;
      7'd10:   k = 32'h0DC53B74;
      7'd11:   k = 32'h995C92A6;
      7'd12:   k = 32'h7E4F6D77;
      7'd13:   k = 32'h1EB2B79F;
      7'd14:   k = 32'h1D348D89;
      7'd15:   k = 32'hED641354;
      7'd16:   k = 32'h15E04A9D;
      7'd17:   k = 32'h488DA159;
      7'd18:   k = 32'h647817D3;
      7'd19:   k = 32'h8CA0BC20;
      7'd20:   k = 32'h9264F7FE;
      7'd21:   k = 32'h91E78C6C;
      7'd22:   k = 32'h5C9A07FB;
      7'd23:   k = 32'hABD4DCCE;
      7'd24:   k = 32'h6416F98D;
      7'd25:   k = 32'h6642AB5B;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t rotl(word_t x, logic [ROT_W-1:0] r);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << r;
    return t[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ----- rtl/core/rc5_round.sv -----
module rc5_round (
  input  rc5_pkg::word_t a,
  input  rc5_pkg::word_t b,
  input  rc5_pkg::word_t key_a,
  input  rc5_pkg::word_t key_b,
  output rc5_pkg::word_t a_out,
  output rc5_pkg::word_t b_out
);

  rc5_pkg::word_t a_mid;

  assign a_mid = rc5_pkg::rotl(a ^ b, b[rc5_pkg::ROT_W-1:0]) + key_a;
  assign a_out = a_mid;
  assign b_out = rc5_pkg::rotl(b ^ a_mid, a_mid[rc5_pkg::ROT_W-1:0]) + key_b;

endmodule

// ----- rtl/core/rc5_seq.sv -----
module rc5_seq #(
  parameter int ROUNDS = rc5_pkg::ROUNDS_DEF,
  parameter int RND_W  = $clog2(ROUNDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_free,
  output rc5_pkg::seq_ctl_t ctl,
  output logic [RND_W-1:0] round_idx
);

  rc5_pkg::seq_state_t state_r, state_nxt;
  logic [RND_W-1:0]    round_r, round_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc5_pkg::ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    ctl       = '0;
    unique case (state_r)
      rc5_pkg::ST_IDLE: begin
        ctl.ready = 1'b1;
        if (in_fire) begin
          ctl.load  = 1'b1;
          round_nxt = RND_W'(1);
          state_nxt = rc5_pkg::ST_RUN;
        end
      end
      rc5_pkg::ST_RUN: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + RND_W'(1);
        if (round_r == RND_W'(ROUNDS)) begin
          state_nxt = rc5_pkg::ST_DONE;
        end
      end
      rc5_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.push  = 1'b1;
          state_nxt = rc5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc5_pkg::ST_IDLE;
    endcase
  end

  assign round_idx = round_r;

endmodule

// ----- rtl/core/rc5_block_encrypt.sv -----
// RC5-32 block encryption, fixed key schedule in a constant table.
// Input channel in_*: one item is a 64-bit plaintext block, word_a in
// in_tdata[31:0], word_b in in_tdata[63:32]. Output channel out_*: one
// item per input, cipher_a in out_tdata[31:0], cipher_b in [63:32].
// An item is taken when tvalid and tready are both high.
// The block holds one item at a time: in_tready is high only while the
// round sequencer is idle. After acceptance the first key pair is added,
// then one round runs per cycle on the shared round unit for ROUNDS
// rounds, and the result then moves to the output register once that
// register is free. A new item is accepted only after the previous
// result has moved to the output register.
// The output register holds a result while the receiver stalls; the
// accepted next item can run its rounds meanwhile, then waits until the
// output register is free.
// Reset (rst_n low, synchronous) empties the output register and returns
// the sequencer to idle; the key table needs no loading.
`include "rc5_block_encrypt_assert.svh"

module rc5_block_encrypt #(
  parameter int ROUNDS = rc5_pkg::ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // word_a, word_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // cipher_a, cipher_b
);

  localparam int RND_W = $clog2(ROUNDS + 1);

  rc5_pkg::seq_ctl_t ctl;
  logic [RND_W-1:0]  round_idx;
  logic              in_fire;
  logic              out_free;

  rc5_pkg::word_t a_r, a_nxt, b_r, b_nxt;
  rc5_pkg::word_t rnd_a, rnd_b;
  rc5_pkg::word_t cipher_a_r, cipher_b_r;
  logic           out_valid_r;

  rc5_pkg::key_idx_t kidx_a, kidx_b;

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = !out_valid_r || out_tready;

  rc5_seq #(
    .ROUNDS (ROUNDS),
    .RND_W  (RND_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_free  (out_free),
    .ctl       (ctl),
    .round_idx (round_idx)
  );

  assign in_tready = ctl.ready;

  assign kidx_a = rc5_pkg::KEY_IDX_W'({round_idx, 1'b0});
  assign kidx_b = rc5_pkg::KEY_IDX_W'({round_idx, 1'b1});

  rc5_round u_round (
    .a     (a_r),
    .b     (b_r),
    .key_a (rc5_pkg::key_at(kidx_a)),
    .key_b (rc5_pkg::key_at(kidx_b)),
    .a_out (rnd_a),
    .b_out (rnd_b)
  );

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (ctl.load) begin
      a_nxt = in_tdata[31:0]  + rc5_pkg::key_at(rc5_pkg::KEY_IDX_W'(0));
      b_nxt = in_tdata[63:32] + rc5_pkg::key_at(rc5_pkg::KEY_IDX_W'(1));
    end else if (ctl.step) begin
      a_nxt = rnd_a;
      b_nxt = rnd_b;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (ctl.push) begin
      cipher_a_r <= a_r;
      cipher_b_r <= b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {cipher_b_r, cipher_a_r};

  `RC5_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready)
  `RC5_ASSERT_NOW(a_push_when_free, ctl.push, out_free)
  `RC5_ASSERT_NEXT(a_first_round, ctl.load, round_idx == RND_W'(1) && ctl.step)
  `RC5_ASSERT_NOW(a_no_overlap, ctl.step, !in_tready && !ctl.push)

endmodule

// ----- sim/tb.sv -----
module tb;
  typedef rc5_pkg::word_t word_t;

  localparam int ROUND_COUNT = rc5_pkg::ROUNDS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam word_t SCHEDULE [26] = '{
    32'hA9915556, 32'h48E44110, 32'h9F32308F, 32'h27F41D3E,
    32'hCF4F3523, 32'hEAC3C6B4, 32'hE9EA5E03, 32'hE5974BBA,
    32'h334D7692, 32'h2C6BCF2E, 32'h0DC53B74, 32'h995C92A6,
    32'h7E4F6D77, 32'h1EB2B79F, 32'h1D348D89, 32'hED641354,
    32'h15E04A9D, 32'h488DA159, 32'h647817D3, 32'h8CA0BC20,
    32'h9264F7FE, 32'h91E78C6C, 32'h5C9A07FB, 32'hABD4DCCE,
    32'h6416F98D, 32'h6642AB5B
  };

  typedef struct {
    word_t a;
    word_t b;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  block_t      cipher_q [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;

  rc5_block_encrypt DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic word_t rot_left(word_t x, word_t amount);
    int unsigned n;
    n = amount & 32'd31;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t sched_word(int unsigned idx);
    if (idx >= 26) return '0;
    return SCHEDULE[idx];
  endfunction

  function automatic block_t rc5_encrypt(block_t plain);
    block_t c;
    c.a = plain.a + sched_word(0);
    c.b = plain.b + sched_word(1);
    for (int unsigned i = 1; i <= ROUND_COUNT; i++) begin
      c.a = rot_left(c.a ^ c.b, c.b) + sched_word(2 * i);
      c.b = rot_left(c.b ^ c.a, c.a) + sched_word(2 * i + 1);
    end
    return c;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 31);
      3: w = ~(word_t'(1) << $urandom_range(0, 31));
      // low five bits pinned, upper bits random
      4: w = {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd0};
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_block(block_t plain);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {plain.b, plain.a};
    do @(posedge clk); while (!in_tready);
    cipher_q.push_back(rc5_encrypt(plain));
  endtask

  task automatic send_random(int count);
    block_t p;
    for (int i = 0; i < count; i++) begin
      p.a = rand_word();
      p.b = rand_word();
      send_block(p);
    end
  endtask

  // receiver side and result check
  always @(posedge clk) begin
    block_t exp_c;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h", out_tdata);
        end else begin
          exp_c = cipher_q.pop_front();
          if (out_tdata[31:0] !== exp_c.a || out_tdata[63:32] !== exp_c.b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: cipher_a exp %h got %h, cipher_b exp %h got %h",
                       exp_c.a, out_tdata[31:0], exp_c.b, out_tdata[63:32]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rc5_block_encrypt");
      $finish;
    end
  end

  initial begin
    block_t directed [] = '{
      '{32'h0000_0000, 32'h0000_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 32'h0000_0000},
      '{32'h0000_0000, 32'hFFFF_FFFF},
      // whitened words become zero: first rotations by zero
      '{32'h566E_AAAA, 32'hB71B_BEF0},
      '{32'h0000_0000, 32'hB71B_BEF0},
      '{32'h566E_AAAA, 32'h0000_0000},
      // rotation amount of exactly 32
      '{32'h1234_5678, 32'hB71B_BF10},
      '{32'hAAAA_AAAA, 32'h5555_5555},
      '{32'h5555_5555, 32'hAAAA_AAAA},
      '{32'h0000_0001, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0000},
      '{32'h0000_0000, 32'h0000_0001},
      '{32'h0000_0000, 32'h8000_0000},
      '{32'h0000_001F, 32'h0000_001F},
      '{32'h0000_0020, 32'h0000_0020},
      '{32'hDEAD_BEEF, 32'h0123_4567},
      '{32'h7FFF_FFFF, 32'h8000_0000},
      '{32'hFFFF_FFE0, 32'h0000_001F},
      '{32'h0F0F_0F0F, 32'hF0F0_F0F0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_stall_pct = 14;
    foreach (directed[i]) send_block(directed[i]);

    send_idle_pct = 0;   recv_stall_pct = 0;   send_random(200);
    send_idle_pct = 59;  recv_stall_pct = 0;   send_random(150);
    send_idle_pct = 0;   recv_stall_pct = 59;  send_random(150);
    send_idle_pct = 14;  recv_stall_pct = 14;  send_random(150);

    // receiver holds off while the sender keeps pushing
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_random(30);
    join
    send_random(150);
    in_tvalid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("PASS rc5_block_encrypt");
    end else begin
      $display("FAIL rc5_block_encrypt");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rc5_pkg.sv
rtl/core/rc5_round.sv
rtl/core/rc5_seq.sv
rtl/core/rc5_block_encrypt.sv
sim/tb.sv
